[hdl/dsqrt_pkg.sv]
// Shared types and constants for the double-precision square root unit.
// No dependencies.
package dsqrt_pkg;

	localparam int unsigned RootBits = 54;
	localparam int unsigned RemBits  = 58;
	localparam int unsigned StepW    = 6;

	localparam logic [1:0] RndNearest = 2'd0;
	localparam logic [1:0] RndZero    = 2'd1;
	localparam logic [1:0] RndUp      = 2'd2;

	localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
	localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
	localparam logic [10:0] ExpAllOnes = 11'h7FF;
	localparam logic [11:0] SubnUe     = 12'd1026;
	localparam logic [11:0] NormUeOff  = 12'd1025;
	localparam logic [10:0] ExpAdjust  = 11'd2;

	localparam logic RegRoundMode = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NORM,
		ST_ALIGN,
		ST_ROOT,
		ST_PACK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic norm_shift;
		logic align;
		logic root_step;
		logic pack;
	} dp_cmd_t;

	typedef struct packed {
		logic special;
		logic normalised;
	} dp_status_t;

endpackage

[hdl/dsqrt_ctrl.sv]
// Sequencing state machine for the square root unit.
// Depends on dsqrt_pkg.
module dsqrt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	output dsqrt_pkg::dp_cmd_t    cmd,
	input  dsqrt_pkg::dp_status_t status
);
	import dsqrt_pkg::*;

	state_t            state_q, state_nxt;
	logic [StepW-1:0]  step_q;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_ALIGN)
				step_q <= '0;
			else if (state_q == ST_ROOT)
				step_q <= step_q + StepW'(1);
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_NORM;
			ST_NORM: begin
				if (status.special)
					state_nxt = ST_OUT;
				else if (status.normalised)
					state_nxt = ST_ALIGN;
			end
			ST_ALIGN: state_nxt = ST_ROOT;
			ST_ROOT:  if (step_q == StepW'(RootBits - 1)) state_nxt = ST_PACK;
			ST_PACK:  state_nxt = ST_OUT;
			ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Drive commands and handshake
	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_NORM:  cmd.norm_shift = !status.special && !status.normalised;
			ST_ALIGN: cmd.align = 1'b1;
			ST_ROOT:  cmd.root_step = 1'b1;
			ST_PACK:  cmd.pack = 1'b1;
			ST_OUT:   out_valid = 1'b1;
			default:  cmd = '0;
		endcase
	end

endmodule

[hdl/dsqrt_dp.sv]
// Datapath: unpack, normalise, restoring root recurrence, round and repack.
// Depends on dsqrt_pkg.
module dsqrt_dp (
	input  logic                  clk,
	input  logic [63:0]           operand,
	input  logic [1:0]            round_mode,
	input  dsqrt_pkg::dp_cmd_t    cmd,
	output dsqrt_pkg::dp_status_t status,
	output logic [63:0]           root,
	output logic                  inexact,
	output logic                  invalid
);
	import dsqrt_pkg::*;

	logic [RootBits-1:0] sig_q;
	logic [11:0]         ue_q;
	logic [RemBits-1:0]  rem_q;
	logic [RootBits-1:0] q_q;
	logic [63:0]         root_q;
	logic                inexact_q, invalid_q, special_q;

	logic [10:0]         expf;
	logic [51:0]         frac;
	logic [RemBits-1:0]  rem_sh, trial, rem_diff;
	logic                take;
	logic                rnz, inc;
	logic [RootBits:0]   q_rnd;
	logic [10:0]         exp_out;

	assign expf = operand[62:52];
	assign frac = operand[51:0];

	// Recurrence step: bring down the next bit pair and try the subtraction
	assign rem_sh   = {rem_q[RemBits-3:0], sig_q[RootBits-1:RootBits-2]};
	assign trial    = {2'b00, q_q, 2'b01};
	assign rem_diff = rem_sh - trial;
	assign take     = (rem_sh >= trial);

	// Rounding increment from the sticky remainder
	always_comb begin
		rnz = (rem_q != '0);
		inc = 1'b0;
		if (rnz) begin
			case (round_mode)
				RndUp:   inc = 1'b1;
				RndZero: inc = 1'b0;
				default: inc = q_q[0];
			endcase
		end
	end
	assign q_rnd   = {1'b0, q_q} + {{(RootBits-1){1'b0}}, inc, 1'b0};
	assign exp_out = ue_q[11:1] - ExpAdjust;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q     <= '0;
			q_q       <= '0;
			inexact_q <= 1'b0;
			invalid_q <= 1'b0;
			special_q <= 1'b1;
			root_q    <= operand;
			sig_q     <= {2'b01, frac};
			ue_q      <= {1'b0, expf} + NormUeOff;
			if (expf == ExpAllOnes) begin
				// NaN, or infinity of either sign
				if (frac != '0) begin
					root_q <= operand | QuietBit;
				end else if (operand[63]) begin
					root_q    <= DefaultNan;
					invalid_q <= 1'b1;
				end
			end else if (operand[62:0] == '0) begin
				// zero returns itself
				root_q <= operand;
			end else if (operand[63]) begin
				root_q    <= DefaultNan;
				invalid_q <= 1'b1;
			end else begin
				special_q <= 1'b0;
				if (expf == '0) begin
					sig_q <= {2'b00, frac};
					ue_q  <= SubnUe;
				end
			end
		end
		// Normalise subnormal significand one bit per cycle
		if (cmd.norm_shift) begin
			sig_q <= {sig_q[RootBits-2:0], 1'b0};
			ue_q  <= ue_q - 12'd1;
		end
		// Double significand for an odd exponent
		if (cmd.align && ue_q[0])
			sig_q <= {sig_q[RootBits-2:0], 1'b0};
		if (cmd.root_step) begin
			sig_q <= {sig_q[RootBits-3:0], 2'b00};
			if (take) begin
				rem_q <= rem_diff;
				q_q   <= {q_q[RootBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[RootBits-2:0], 1'b0};
			end
		end
		// Repack with half the exponent
		if (cmd.pack) begin
			root_q    <= {1'b0, exp_out, 52'd0} + {10'd0, q_rnd[RootBits:1]};
			inexact_q <= rnz;
			invalid_q <= 1'b0;
		end
	end

	assign status.special    = special_q;
	assign status.normalised = sig_q[52];
	assign root    = root_q;
	assign inexact = inexact_q;
	assign invalid = invalid_q;

endmodule

[hdl/double_sqrt_bit_by_bit_unit.sv]
// Top level of the double-precision square root unit: register port and wiring.
// Depends on dsqrt_pkg, dsqrt_ctrl and dsqrt_dp.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, operand           | in beat
//  out     | out_valid, out_stall, root, inexact,  | out beat
//          | invalid                               |
//  cfg     | psel, penable, pwrite, paddr, pwdata, | register
//          | prdata, pready                        |
//
// A normal operand passes from accept to result beat through normalise, align, 54
// root steps, pack and output; a subnormal first normalises one bit per cycle, up
// to 52 shifts. Specials (NaN, infinities, zeros, negatives) go from normalise to
// output. The root recurrence yields one bit per cycle. One beat is in flight at a
// time; in_stall is high until the result beat leaves, so the next operand is
// accepted the cycle after at the earliest. Reset clears the sequencer and round_mode.
module double_sqrt_bit_by_bit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] operand,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] root,
	output logic        inexact,
	output logic        invalid,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dsqrt_pkg::*;

	logic [1:0] round_mode_q;
	dp_cmd_t    cmd;
	dp_status_t status;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == RegRoundMode) && (paddr[1:0] == 2'b00);

	// Hold the rounding mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_mode_q <= RndNearest;
		else if (psel && penable && pwrite && reg_hit)
			round_mode_q <= pwdata[1:0];
	end

	assign prdata = reg_hit ? {30'd0, round_mode_q} : 32'd0;

	dsqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	dsqrt_dp u_dp (
		.clk        (clk),
		.operand    (operand),
		.round_mode (round_mode_q),
		.cmd        (cmd),
		.status     (status),
		.root       (root),
		.inexact    (inexact),
		.invalid    (invalid)
	);

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the double-precision bit-by-bit square root unit.
// Depends on dsqrt_pkg and double_sqrt_bit_by_bit_unit; predicts every root beat.
module tb;
	import dsqrt_pkg::*;

	typedef struct {
		logic [63:0] root;
		logic        inexact;
		logic        invalid;
	} sqrt_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] operand;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] root;
	logic        inexact;
	logic        invalid;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sqrt_res_t   pending_roots[$];
	logic [1:0]  rnd_mode;
	int          n_errors;
	int          idle_cycles;
	bit          sink_idle_on;
	bit          src_idle_on;
	int          hold_off;

	double_sqrt_bit_by_bit_unit uut (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Restoring root of (sig << 54), 54 result bits
	function automatic logic [63:0] isqrt54(input logic [63:0] sig, output logic rem_nz);
		logic [63:0] rem;
		logic [63:0] q;
		logic [63:0] pair;
		logic [63:0] trial;
		rem = '0;
		q = '0;
		for (int k = 0; k < 54; k++) begin
			pair = (k < 27) ? ((sig >> (52 - 2 * k)) & 64'd3) : 64'd0;
			rem = (rem << 2) | pair;
			trial = (q << 2) | 64'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				q = (q << 1) | 64'd1;
			end else begin
				q = q << 1;
			end
		end
		rem_nz = (rem != 0);
		return q;
	endfunction

	function automatic sqrt_res_t predict_root(input logic [63:0] x);
		sqrt_res_t r;
		logic [10:0] ef;
		logic [51:0] fr;
		logic [63:0] sig;
		logic [63:0] q;
		logic        nz;
		int          ue;
		r.root = x;
		r.inexact = 1'b0;
		r.invalid = 1'b0;
		ef = x[62:52];
		fr = x[51:0];
		if (ef == ExpAllOnes) begin
			if (fr != 0) r.root = x | QuietBit;
			else if (x[63]) begin
				r.root = DefaultNan;
				r.invalid = 1'b1;
			end
			return r;
		end
		if (x[62:0] == 0) return r;
		if (x[63]) begin
			r.root = DefaultNan;
			r.invalid = 1'b1;
			return r;
		end
		if (ef == 0) begin
			sig = {12'd0, fr};
			ue = 1 - 1023 + 2048;
			while (sig[52] == 1'b0) begin
				sig = sig << 1;
				ue--;
			end
		end else begin
			sig = {11'd0, 1'b1, fr};
			ue = int'(ef) - 1023 + 2048;
		end
		if (ue & 1) sig = sig << 1;
		q = isqrt54(sig, nz);
		if (nz) begin
			r.inexact = 1'b1;
			if (rnd_mode == RndUp) q = q + 64'd2;
			else if (rnd_mode != RndZero) q = q + {63'd0, q[0]};
		end
		r.root = ({52'd0, 12'((ue >> 1) - 2)} << 52) + (q >> 1);
		return r;
	endfunction

	// Send one operand beat, with an optional idle burst first
	task automatic send_operand(input logic [63:0] x);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operand <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_roots.push_back(predict_root(x));
	endtask

	// Drop valid, wait until every expected beat is out, then let the unit settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_roots.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_round_mode(input logic [1:0] m);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {RegRoundMode, 2'b00};
		pwdata <= {30'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rnd_mode = m;
	endtask

	// Random double with a bias towards interesting exponents
	function automatic logic [63:0] rand_double();
		logic [63:0] x;
		x = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: x[62:52] = 11'd0;
			1: x[62:52] = ExpAllOnes;
			2: x[62:0] = 63'd0;
			3, 4: x[63] = 1'b1;
			default: x[63] = 1'b0;
		endcase
		if ($urandom_range(0, 5) == 0) x[31:0] = 32'd0;
		return x;
	endfunction

	task automatic test_specials();
		logic [63:0] vals[$];
		vals = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
			64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFF7_FFFF_FFFF_FFFF,
			64'h7FF8_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF, 64'h0008_0000_0000_0000,
			64'h0010_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
			64'h4000_0000_0000_0000, 64'h4010_0000_0000_0000, 64'h4022_0000_0000_0000,
			64'h3FF0_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF};
		foreach (vals[i]) send_operand(vals[i]);
	endtask

	task automatic test_round_modes();
		for (int m = 0; m < 4; m++) begin
			drain();
			write_round_mode(m[1:0]);
			send_operand(64'h4000_0000_0000_0000);
			send_operand(64'h3FF0_0000_0000_0001);
			send_operand(64'h7FEF_FFFF_FFFF_FFFF);
			for (int i = 0; i < 40; i++) send_operand(rand_double());
		end
	endtask

	// Hold the sink off long enough for the unit to fill and stall its input
	task automatic test_backpressure();
		hold_off = 300;
		for (int i = 0; i < 4; i++) send_operand(rand_double());
	endtask

	task automatic test_random();
		drain();
		write_round_mode(RndNearest);
		for (int i = 0; i < 420; i++) begin
			if (i == 360) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end
			send_operand(rand_double());
		end
	endtask

	// Sink stall generator
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off > 0) begin
				out_stall <= 1'b1;
				hold_off--;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5) - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check each root beat against the oldest prediction
	always @(posedge clk) begin
		sqrt_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_roots.size() == 0) begin
				$error("unexpected root beat %h", root);
				n_errors++;
			end else begin
				e = pending_roots.pop_front();
				if (root !== e.root) begin
					$error("root: expected %h actual %h", e.root, root);
					n_errors++;
				end
				if (inexact !== e.inexact) begin
					$error("inexact: expected %b actual %b", e.inexact, inexact);
					n_errors++;
				end
				if (invalid !== e.invalid) begin
					$error("invalid: expected %b actual %b", e.invalid, invalid);
					n_errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operand = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rnd_mode = RndNearest;
		n_errors = 0;
		idle_cycles = 0;
		hold_off = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_specials();
		test_round_modes();
		test_backpressure();
		test_random();
		drain();
		if (n_errors == 0 && pending_roots.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

[files.f]
hdl/dsqrt_pkg.sv
hdl/dsqrt_ctrl.sv
hdl/dsqrt_dp.sv
hdl/double_sqrt_bit_by_bit_unit.sv
bench/tb.sv
